// ===== src/extint_pkg.sv =====
// ----------------------------------------------------------------------------
// extint_pkg
// Types and constants shared by the external and pin-change interrupt
// controller and its evaluation logic.
// ----------------------------------------------------------------------------
package extint_pkg;

    localparam int MAX_EXT_PINS  = 4;
    localparam int MAX_PC_BANKS  = 3;
    localparam int PINS_PER_BANK = 8;

    typedef enum logic [2:0] {
        MODE_EXT_PIN = 3'd0,
        MODE_PC_PIN  = 3'd1,
        MODE_EXT_WR  = 3'd2,
        MODE_PC_WR   = 3'd3,
        MODE_EXT_ACK = 3'd4,
        MODE_PC_ACK  = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        SENSE_LOW     = 2'd0,
        SENSE_TOGGLE  = 2'd1,
        SENSE_FALLING = 2'd2,
        SENSE_RISING  = 2'd3
    } sense_t;

    localparam logic [2:0] CFG_SENSE_MODES = 3'd0;
    localparam logic [2:0] CFG_EXT_ENABLE  = 3'd1;
    localparam logic [2:0] CFG_PC_MASK0    = 3'd2;

    typedef struct packed {
        logic [2:0] mode;
        logic [4:0] pin_number;
        logic       new_level;
        logic [7:0] write_value;
        logic [1:0] ack_index;
    } item_t;

    typedef struct packed {
        logic [3:0] raise_ext;
        logic [2:0] raise_pc;
        logic [3:0] cancel_ext;
        logic [2:0] cancel_pc;
        logic [3:0] ext_flag_bits;
        logic [2:0] pc_flag_bits;
        logic       event_valid;
        logic       event_is_pc;
        logic [1:0] event_levels;
        logic [4:0] event_pin;
    } result_t;

endpackage

// ===== src/extint_if.sv =====
// ----------------------------------------------------------------------------
// extint_if
// Valid/ready channels of the interrupt controller: input words, result
// words and configuration writes.
// ----------------------------------------------------------------------------
interface extint_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [4:0] pin_number;
    logic       new_level;
    logic [7:0] write_value;
    logic [1:0] ack_index;

    modport source (output valid, mode, pin_number, new_level, write_value, ack_index,
                    input ready);
    modport sink (input valid, mode, pin_number, new_level, write_value, ack_index,
                  output ready);
endinterface

interface extint_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] raise_ext;
    logic [2:0] raise_pc;
    logic [3:0] cancel_ext;
    logic [2:0] cancel_pc;
    logic [3:0] ext_flag_bits;
    logic [2:0] pc_flag_bits;
    logic       event_valid;
    logic       event_is_pc;
    logic [1:0] event_levels;
    logic [4:0] event_pin;

    modport source (output valid, raise_ext, raise_pc, cancel_ext, cancel_pc,
                    ext_flag_bits, pc_flag_bits, event_valid, event_is_pc,
                    event_levels, event_pin,
                    input ready);
    modport sink (input valid, raise_ext, raise_pc, cancel_ext, cancel_pc,
                  ext_flag_bits, pc_flag_bits, event_valid, event_is_pc,
                  event_levels, event_pin,
                  output ready);
endinterface

interface extint_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/external_and_pin_change_interrupt.sv =====
// ----------------------------------------------------------------------------
// external_and_pin_change_interrupt
// A word accepted into the input register is evaluated and then registered
// into the result register. Throughput: one word per cycle while results are taken.
// The input register and the result register each hold one word, so input
// is taken every cycle while results are taken every cycle.
// Reset clears configuration, pin levels, flags and both valid bits.
// ----------------------------------------------------------------------------
module external_and_pin_change_interrupt
    import extint_pkg::*;
#(
    parameter int EXT_PINS = 4,
    parameter int PC_BANKS = 3
) (
    input  logic         clk,
    input  logic         rst_n,
    extint_req_if.sink   req,
    extint_rsp_if.source rsp,
    extint_cfg_if.sink   cfg
);

    logic [2*EXT_PINS-1:0]                  sense_modes_reg;
    logic [EXT_PINS-1:0]                    ext_enable_reg;
    logic [PC_BANKS-1:0][PINS_PER_BANK-1:0] pc_mask_reg;

    logic [EXT_PINS-1:0]                    ext_levels_reg;
    logic [PC_BANKS-1:0][PINS_PER_BANK-1:0] pc_levels_reg;
    logic [EXT_PINS-1:0]                    ext_flags_reg;
    logic [PC_BANKS-1:0]                    pc_flags_reg;

    logic [EXT_PINS-1:0]                    ext_levels_next;
    logic [PC_BANKS-1:0][PINS_PER_BANK-1:0] pc_levels_next;
    logic [EXT_PINS-1:0]                    ext_flags_next;
    logic [PC_BANKS-1:0]                    pc_flags_next;

    logic    item_valid_reg;
    item_t   item_reg;
    logic    out_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    advance;

    assign advance   = !out_valid_reg || rsp.ready;
    assign req.ready = !item_valid_reg || advance;
    assign cfg.ready = 1'b1;

    extint_eval #(
        .EXT_PINS (EXT_PINS),
        .PC_BANKS (PC_BANKS)
    ) u_eval (
        .item            (item_reg),
        .sense_modes     (sense_modes_reg),
        .ext_enable      (ext_enable_reg),
        .pc_mask         (pc_mask_reg),
        .ext_levels      (ext_levels_reg),
        .pc_levels       (pc_levels_reg),
        .ext_flags       (ext_flags_reg),
        .pc_flags        (pc_flags_reg),
        .ext_levels_next (ext_levels_next),
        .pc_levels_next  (pc_levels_next),
        .ext_flags_next  (ext_flags_next),
        .pc_flags_next   (pc_flags_next),
        .result          (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sense_modes_reg <= '0;
            ext_enable_reg  <= '0;
            pc_mask_reg     <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_SENSE_MODES: sense_modes_reg <= cfg.data[2*EXT_PINS-1:0];
                CFG_EXT_ENABLE:  ext_enable_reg  <= cfg.data[EXT_PINS-1:0];
                default:
                begin
                    for (int b = 0; b < PC_BANKS; b++)
                    begin
                        if (cfg.index == 3'(CFG_PC_MASK0 + 3'(b)))
                        begin
                            pc_mask_reg[b] <= cfg.data;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            ext_levels_reg <= '0;
            pc_levels_reg  <= '0;
            ext_flags_reg  <= '0;
            pc_flags_reg   <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                item_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= item_valid_reg;
                if (item_valid_reg)
                begin
                    ext_levels_reg <= ext_levels_next;
                    pc_levels_reg  <= pc_levels_next;
                    ext_flags_reg  <= ext_flags_next;
                    pc_flags_reg   <= pc_flags_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            item_reg.mode        <= req.mode;
            item_reg.pin_number  <= req.pin_number;
            item_reg.new_level   <= req.new_level;
            item_reg.write_value <= req.write_value;
            item_reg.ack_index   <= req.ack_index;
        end
        if (advance && item_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.raise_ext     = result_reg.raise_ext;
    assign rsp.raise_pc      = result_reg.raise_pc;
    assign rsp.cancel_ext    = result_reg.cancel_ext;
    assign rsp.cancel_pc     = result_reg.cancel_pc;
    assign rsp.ext_flag_bits = result_reg.ext_flag_bits;
    assign rsp.pc_flag_bits  = result_reg.pc_flag_bits;
    assign rsp.event_valid   = result_reg.event_valid;
    assign rsp.event_is_pc   = result_reg.event_is_pc;
    assign rsp.event_levels  = result_reg.event_levels;
    assign rsp.event_pin     = result_reg.event_pin;

endmodule

// ===== src/extint_eval.sv =====
// ----------------------------------------------------------------------------
// extint_eval
// Combinational evaluation of one input word against the pin levels, flags
// and configuration: next state and the result word.
// ----------------------------------------------------------------------------
module extint_eval
    import extint_pkg::*;
#(
    parameter int EXT_PINS = 4,
    parameter int PC_BANKS = 3
) (
    input  item_t                                 item,
    input  logic [2*EXT_PINS-1:0]                 sense_modes,
    input  logic [EXT_PINS-1:0]                   ext_enable,
    input  logic [PC_BANKS-1:0][PINS_PER_BANK-1:0] pc_mask,
    input  logic [EXT_PINS-1:0]                   ext_levels,
    input  logic [PC_BANKS-1:0][PINS_PER_BANK-1:0] pc_levels,
    input  logic [EXT_PINS-1:0]                   ext_flags,
    input  logic [PC_BANKS-1:0]                   pc_flags,
    output logic [EXT_PINS-1:0]                   ext_levels_next,
    output logic [PC_BANKS-1:0][PINS_PER_BANK-1:0] pc_levels_next,
    output logic [EXT_PINS-1:0]                   ext_flags_next,
    output logic [PC_BANKS-1:0]                   pc_flags_next,
    output result_t                               result
);

    logic [EXT_PINS-1:0] low_persists;
    logic [EXT_PINS-1:0] ext_trig;
    logic [1:0]          bank;
    logic [2:0]          bit_sel;

    assign bank    = item.pin_number[4:3];
    assign bit_sel = item.pin_number[2:0];

    always_comb
    begin
        for (int i = 0; i < EXT_PINS; i++)
        begin
            low_persists[i] = (sense_t'(sense_modes[2*i +: 2]) == SENSE_LOW)
                              && !ext_levels[i] && ext_enable[i];
            case (sense_t'(sense_modes[2*i +: 2]))
                SENSE_LOW:     ext_trig[i] = !item.new_level;
                SENSE_TOGGLE:  ext_trig[i] = item.new_level != ext_levels[i];
                SENSE_FALLING: ext_trig[i] = !item.new_level && ext_levels[i];
                SENSE_RISING:  ext_trig[i] = item.new_level && !ext_levels[i];
                default:       ext_trig[i] = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        ext_levels_next = ext_levels;
        pc_levels_next  = pc_levels;
        ext_flags_next  = ext_flags;
        pc_flags_next   = pc_flags;
        result          = '0;

        case (mode_t'(item.mode))
            MODE_EXT_PIN:
            begin
                for (int i = 0; i < EXT_PINS; i++)
                begin
                    if (item.pin_number == 5'(i))
                    begin
                        if (ext_trig[i] && ext_enable[i])
                        begin
                            ext_flags_next[i]   = 1'b1;
                            result.raise_ext[i] = 1'b1;
                            result.event_valid  = 1'b1;
                            result.event_levels = {ext_levels[i], item.new_level};
                            result.event_pin    = item.pin_number;
                        end
                        ext_levels_next[i] = item.new_level;
                    end
                end
            end
            MODE_PC_PIN:
            begin
                for (int b = 0; b < PC_BANKS; b++)
                begin
                    if (bank == 2'(b))
                    begin
                        if (pc_mask[b][bit_sel] && (pc_levels[b][bit_sel] != item.new_level))
                        begin
                            pc_flags_next[b]    = 1'b1;
                            result.raise_pc[b]  = 1'b1;
                            result.event_valid  = 1'b1;
                            result.event_is_pc  = 1'b1;
                            result.event_levels = {pc_levels[b][bit_sel], item.new_level};
                            result.event_pin    = item.pin_number;
                        end
                        pc_levels_next[b][bit_sel] = item.new_level;
                    end
                end
            end
            MODE_EXT_WR:
            begin
                for (int i = 0; i < EXT_PINS; i++)
                begin
                    if (item.write_value[i])
                    begin
                        ext_flags_next[i]    = 1'b0;
                        result.cancel_ext[i] = !low_persists[i];
                    end
                end
            end
            MODE_PC_WR:
            begin
                for (int b = 0; b < PC_BANKS; b++)
                begin
                    if (item.write_value[b])
                    begin
                        pc_flags_next[b]    = 1'b0;
                        result.cancel_pc[b] = 1'b1;
                    end
                end
            end
            MODE_EXT_ACK:
            begin
                for (int i = 0; i < EXT_PINS; i++)
                begin
                    if (item.ack_index == 2'(i))
                    begin
                        if (low_persists[i])
                        begin
                            result.raise_ext[i] = 1'b1;
                        end
                        else
                        begin
                            ext_flags_next[i] = 1'b0;
                        end
                    end
                end
            end
            MODE_PC_ACK:
            begin
                for (int b = 0; b < PC_BANKS; b++)
                begin
                    if (item.ack_index == 2'(b))
                    begin
                        pc_flags_next[b] = 1'b0;
                    end
                end
            end
            default:
            begin
                ext_flags_next = ext_flags;
            end
        endcase

        for (int i = 0; i < EXT_PINS; i++)
        begin
            result.ext_flag_bits[i] = ext_flags_next[i];
        end
        for (int b = 0; b < PC_BANKS; b++)
        begin
            result.pc_flag_bits[b] = pc_flags_next[b];
        end
    end

endmodule
